/* rtl/core/dks_pkg.sv */
`timescale 1ns / 1ps
// dks_pkg: constants and types shared by the descending key sorter
// no dependencies; compiled before every other file of the block

package dks_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int YEAR_W      = 14;
    localparam int ID_W        = 16;
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    // one slot of the sorting chain
    typedef struct packed {
        logic              valid;
        logic [YEAR_W-1:0] key;
        logic [ID_W-1:0]   id;
    } dks_rec_t;

    // control broadcast to every cell
    typedef struct packed {
        logic              insert;
        logic              pop;
        logic [YEAR_W-1:0] new_key;
        logic [ID_W-1:0]   new_id;
    } dks_ctrl_t;

endpackage

/* rtl/core/dks_if.sv */
`timescale 1ns / 1ps
// dks_in_if / dks_out_if: valid/ready channels of the descending key sorter
// depends on dks_pkg for field widths

interface dks_in_if
    import dks_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [YEAR_W-1:0] birth_year;
    logic [ID_W-1:0]   record_id;
    logic              final_item;

    modport source (output valid, output birth_year, output record_id, output final_item,
                    input ready);
    modport sink (input valid, input birth_year, input record_id, input final_item,
                  output ready);
endinterface

interface dks_out_if
    import dks_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [YEAR_W-1:0] sorted_year;
    logic [ID_W-1:0]   sorted_id;
    logic              end_of_run;
    logic              overflowed;

    modport source (output valid, output sorted_year, output sorted_id, output end_of_run,
                    output overflowed, input ready);
    modport sink (input valid, input sorted_year, input sorted_id, input end_of_run,
                  input overflowed, output ready);
endinterface

/* rtl/core/dks_cell.sv */
`timescale 1ns / 1ps
// dks_cell: one slot of the insertion chain, holds a record in descending order
// depends on dks_pkg

module dks_cell
    import dks_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dks_ctrl_t ctrl,
    input  dks_rec_t  left_rec,
    input  logic      left_pass,
    input  dks_rec_t  right_rec,
    output dks_rec_t  rec,
    output logic      pass
);

    logic              valid_reg;
    logic              valid_next;
    logic [YEAR_W-1:0] key_reg;
    logic [YEAR_W-1:0] key_next;
    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   id_next;

    // new record belongs ahead of this slot's content
    assign pass = !(valid_reg && (key_reg >= ctrl.new_key));

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        id_next    = id_reg;
        if (ctrl.insert && pass)
        begin
            if (left_pass)
            begin
                valid_next = left_rec.valid;
                key_next   = left_rec.key;
                id_next    = left_rec.id;
            end
            else
            begin
                valid_next = 1'b1;
                key_next   = ctrl.new_key;
                id_next    = ctrl.new_id;
            end
        end
        else if (ctrl.pop)
        begin
            valid_next = right_rec.valid;
            key_next   = right_rec.key;
            id_next    = right_rec.id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        id_reg  <= id_next;
    end

    assign rec.valid = valid_reg;
    assign rec.key   = key_reg;
    assign rec.id    = id_reg;

endmodule

/* rtl/core/descending_key_sorter_unit.sv */
`timescale 1ns / 1ps
// descending_key_sorter_unit: top level, chain of dks_cell slots and output register
// depends on dks_pkg, dks_in_if, dks_out_if, dks_cell

// Records are loaded one transaction per cycle into a chain of MAX_RECORDS
// slots that keeps them sorted by year, largest first, equal years in load
// order. The transaction with final_item set ends the set; from the next
// cycle on the chain shifts out one record per cycle into the output
// register whenever the sink does not stall. Input is not taken while the
// set is being delivered; the port becomes ready again in the cycle the
// last result (end_of_run) is shown. Records beyond MAX_RECORDS are
// dropped and every result of that set carries overflowed.

module descending_key_sorter_unit
    import dks_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dks_in_if.sink    records,
    dks_out_if.source results
);

    dks_rec_t  cell_rec [MAX_RECORDS];
    logic      cell_pass [MAX_RECORDS];
    dks_ctrl_t ctrl;

    logic [CNT_W-1:0]  fill_count_reg;
    logic [CNT_W-1:0]  fill_count_next;
    logic              overflow_reg;
    logic              overflow_next;
    logic              draining_reg;
    logic              draining_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [YEAR_W-1:0] out_year_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic              out_end_reg;
    logic              out_ovf_reg;

    logic accept;
    logic full;
    logic pop;
    logic last_pop;

    localparam dks_rec_t EMPTY_REC = '0;

    assign records.ready = !draining_reg;
    assign accept        = records.valid && records.ready;
    assign full          = (fill_count_reg == CNT_W'(MAX_RECORDS));
    assign pop           = draining_reg && (!out_valid_reg || results.ready);
    assign last_pop      = pop && (fill_count_reg == CNT_W'(1));

    assign ctrl.insert  = accept && !full;
    assign ctrl.pop     = pop;
    assign ctrl.new_key = records.birth_year;
    assign ctrl.new_id  = records.record_id;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RECORDS; gi++)
        begin : g_cell
            dks_rec_t left_rec;
            logic     left_pass;
            dks_rec_t right_rec;

            if (gi == 0)
            begin : g_first
                assign left_rec  = EMPTY_REC;
                assign left_pass = 1'b0;
            end
            else
            begin : g_mid
                assign left_rec  = cell_rec[gi-1];
                assign left_pass = cell_pass[gi-1];
            end

            if (gi == MAX_RECORDS - 1)
            begin : g_last
                assign right_rec = EMPTY_REC;
            end
            else
            begin : g_inner
                assign right_rec = cell_rec[gi+1];
            end

            dks_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .left_rec  (left_rec),
                .left_pass (left_pass),
                .right_rec (right_rec),
                .rec       (cell_rec[gi]),
                .pass      (cell_pass[gi])
            );
        end
    endgenerate

    always_comb
    begin
        fill_count_next = fill_count_reg;
        overflow_next   = overflow_reg;
        draining_next   = draining_reg;
        if (ctrl.insert)
        begin
            fill_count_next = fill_count_reg + CNT_W'(1);
        end
        else if (pop)
        begin
            fill_count_next = fill_count_reg - CNT_W'(1);
        end
        if (accept && full)
        begin
            overflow_next = 1'b1;
        end
        else if (last_pop)
        begin
            overflow_next = 1'b0;
        end
        if (accept && records.final_item)
        begin
            draining_next = 1'b1;
        end
        else if (last_pop)
        begin
            draining_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            overflow_reg   <= 1'b0;
            draining_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            overflow_reg   <= overflow_next;
            draining_reg   <= draining_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_year_reg <= cell_rec[0].key;
            out_id_reg   <= cell_rec[0].id;
            out_end_reg  <= (fill_count_reg == CNT_W'(1));
            out_ovf_reg  <= overflow_reg;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.sorted_year = out_year_reg;
    assign results.sorted_id   = out_id_reg;
    assign results.end_of_run  = out_end_reg;
    assign results.overflowed  = out_ovf_reg;

endmodule

/* rtl/core/dks_checker.sv */
`timescale 1ns / 1ps
// dks_checker: port-level assertions for descending_key_sorter_unit
// depends on dks_pkg; bound to the top level at the end of this file

module dks_checker
    import dks_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              in_final,
    input logic              out_valid,
    input logic              out_ready,
    input logic [YEAR_W-1:0] out_year,
    input logic              out_end
);

    // after a final transaction the input must no longer be ready
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_final |=> !in_ready)
        else $error("input still ready after final transaction");

    // input reopens only together with the last result of the run
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid && out_end)
        else $error("input reopened without end of run");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_year))
        else $error("result changed while stalled");

endmodule

bind descending_key_sorter_unit dks_checker u_dks_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (records.valid),
    .in_ready  (records.ready),
    .in_final  (records.final_item),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_year  (results.sorted_year),
    .out_end   (results.end_of_run)
);
